FILE: rtl/core/tla_pkg.sv
// Package for the transaction label allocator.
// Holds sizes, request and status codes and the per-node entry type.
// Used by transaction_label_allocator_core; depends on nothing.
`default_nettype none

package tla_pkg;

  localparam int NODES    = 64;
  localparam int LABELS   = 64;

  localparam int NODE_W   = 6;
  localparam int LABEL_W  = 6;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;

  localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LABEL_AW = $clog2(LABELS);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_LABEL = 2'd1,
    ST_NOT_USED = 2'd2
  } status_e;

  typedef struct packed {
    logic [LABELS-1:0]   map;
    logic [LABEL_AW-1:0] start;
    logic [CNT_W-1:0]    cnt;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/transaction_label_allocator_core.sv
// Transaction label allocator core: per-node label maps in one memory.
// Depends on tla_pkg for sizes, codes and the entry type.
// Frees and allocates refused for a bad node or the limit register a result from S_RD.
// A granted allocate goes through S_RD and S_SRCH, skipping k busy labels in the
// one-label-per-cycle search unit (at most LABELS-1); a failed scan tries all LABELS.
// The next request is taken at the edge after a result is registered.
// Reset clears the per-node valid bits at once; no clearing pass; limit resets to 63.
`default_nettype none

module transaction_label_allocator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_we_i,
  input  wire logic [tla_pkg::CNT_W-1:0]     cfg_wdata_i,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          in_req_type_i,
  input  wire logic [tla_pkg::NODE_W-1:0]    in_node_i,
  input  wire logic [tla_pkg::LABEL_W-1:0]   in_label_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tla_pkg::STATUS_W-1:0]       out_status_o,
  output logic [tla_pkg::LABEL_W-1:0]        out_granted_label_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  localparam logic [tla_pkg::LABEL_AW-1:0] LAST_LABEL =
    tla_pkg::LABEL_AW'(tla_pkg::LABELS - 1);

  logic [1:0]                      state_q, state_d;
  logic [tla_pkg::CNT_W-1:0]       max_q;

  logic                            req_q;
  logic [tla_pkg::NODE_AW-1:0]     addr_q;
  logic [tla_pkg::LABEL_AW-1:0]    lab_q;
  logic                            node_ok_q;
  logic                            lab_ok_q;

  tla_pkg::entry_t                 mem [tla_pkg::NODES];
  tla_pkg::entry_t                 mem_rd_q;
  logic [tla_pkg::NODES-1:0]       nvld_q;
  logic                            vld_rd_q;

  tla_pkg::entry_t                 work_q, work_d;
  logic [tla_pkg::LABEL_AW-1:0]    cand_q, cand_d;
  logic [tla_pkg::LABEL_AW-1:0]    step_q, step_d;
  logic [tla_pkg::LABEL_AW-1:0]    cand_next;

  logic                            out_valid_q;
  logic [tla_pkg::STATUS_W-1:0]    out_status_q;
  logic [tla_pkg::LABEL_W-1:0]     out_label_q;

  logic                            in_accept;
  logic                            can_fin;
  logic                            fin;
  logic                            wr_en;
  tla_pkg::entry_t                 wr_entry;
  tla_pkg::entry_t                 rd_entry;
  tla_pkg::status_e                res_status;
  logic [tla_pkg::LABEL_W-1:0]     res_label;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign can_fin = !out_valid_q || !out_stall_i;
  assign rd_entry = vld_rd_q ? mem_rd_q : '0;
  assign cand_next = (cand_q == LAST_LABEL) ? '0 : cand_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    work_d     = work_q;
    cand_d     = cand_q;
    step_d     = step_q;
    fin        = 1'b0;
    wr_en      = 1'b0;
    wr_entry   = rd_entry;
    res_status = tla_pkg::ST_NO_LABEL;
    res_label  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (req_q == tla_pkg::REQ_FREE) begin
          fin        = 1'b1;
          res_status = tla_pkg::ST_NOT_USED;
          if (node_ok_q && lab_ok_q && rd_entry.map[lab_q]) begin
            wr_en              = 1'b1;
            wr_entry.map[lab_q] = 1'b0;
            if (rd_entry.cnt != '0) begin
              wr_entry.cnt = rd_entry.cnt - 1'b1;
            end
            res_status = tla_pkg::ST_OK;
          end
        end else if (node_ok_q && (rd_entry.cnt < max_q)) begin
          work_d  = rd_entry;
          cand_d  = rd_entry.start;
          step_d  = '0;
          state_d = S_SRCH;
        end else begin
          fin = 1'b1;
        end
      end
      S_SRCH: begin
        if (!work_q.map[cand_q]) begin
          fin                  = 1'b1;
          wr_en                = 1'b1;
          wr_entry             = work_q;
          wr_entry.map[cand_q] = 1'b1;
          wr_entry.start       = cand_next;
          wr_entry.cnt         = work_q.cnt + 1'b1;
          res_status           = tla_pkg::ST_OK;
          res_label            = tla_pkg::LABEL_W'(cand_q);
        end else if (step_q == LAST_LABEL) begin
          fin = 1'b1;
        end else begin
          cand_d = cand_next;
          step_d = step_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      state_d = can_fin ? S_IDLE : state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= tla_pkg::CNT_W'(63);
      nvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (wr_en && can_fin) begin
        nvld_q[addr_q] <= 1'b1;
      end
      if (fin && can_fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q     <= in_req_type_i;
      addr_q    <= in_node_i[tla_pkg::NODE_AW-1:0];
      lab_q     <= in_label_i[tla_pkg::LABEL_AW-1:0];
      node_ok_q <= ({1'b0, in_node_i} < (tla_pkg::NODE_W+1)'(tla_pkg::NODES));
      lab_ok_q  <= ({1'b0, in_label_i} < (tla_pkg::LABEL_W+1)'(tla_pkg::LABELS));
      mem_rd_q  <= mem[in_node_i[tla_pkg::NODE_AW-1:0]];
      vld_rd_q  <= nvld_q[in_node_i[tla_pkg::NODE_AW-1:0]];
    end
    if (wr_en && can_fin) begin
      mem[addr_q] <= wr_entry;
    end
    work_q <= work_d;
    cand_q <= cand_d;
    step_q <= step_d;
    if (fin && can_fin) begin
      out_status_q <= res_status;
      out_label_q  <= res_label;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_granted_label_o = out_label_q;

`ifndef SYNTHESIS
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_RD))
    else $error("accepted beat did not start a memory read");

  a_fail_no_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o != tla_pkg::ST_OK)) |-> (out_granted_label_o == '0))
    else $error("failed request reported a nonzero label");

  a_wr_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == S_RD) || (state_q == S_SRCH)))
    else $error("memory write outside a request");

  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && can_fin) |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("finished request did not register a result");
`endif

endmodule

`default_nettype wire
